FILE: sv/brlc_pkg.sv
`default_nettype none

package brlc_pkg;

   // largest decoded payload a stream may declare
   localparam logic [31:0] MAX_PAYLOAD_BYTES = 32'd1073741824;

   // longest run one pair can carry
   localparam logic [7:0] MAX_RUN = 8'd255;

   // byte lanes in one result word
   localparam int LANES = 8;

   // configuration register indexes
   localparam logic CSR_DECODE_MODE   = 1'b0;
   localparam logic CSR_EXPECTED_SIZE = 1'b1;

   // result status codes
   localparam logic [2:0] STATUS_OK            = 3'd0;
   localparam logic [2:0] STATUS_ODD_LENGTH    = 3'd1;
   localparam logic [2:0] STATUS_ZERO_COUNT    = 3'd2;
   localparam logic [2:0] STATUS_OVERFLOW      = 3'd3;
   localparam logic [2:0] STATUS_SIZE_MISMATCH = 3'd4;
   localparam logic [2:0] STATUS_OVER_LIMIT    = 3'd5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] out_word;
      logic [3:0]  out_count;
      logic        out_last;
      logic [2:0]  status;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_ENC_FLUSH,
      ST_ENC_LAST,
      ST_DEC_EXPAND,
      ST_DEC_FINAL
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic eval;
      logic emit_flush;
      logic emit_last_pair;
      logic emit_expand;
      logic emit_final;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic decode_mode;
      logic item_last;
      logic enc_split;
      logic pair_phase;
      logic dec_error;
      logic expand_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: sv/brlc_ctrl.sv
`default_nettype none

module brlc_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  brlc_pkg::dp_status_type dp_status,
   output brlc_pkg::cmd_type       cmd
);
   import brlc_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!dp_status.decode_mode) begin
               if (dp_status.enc_split) begin
                  state_in = ST_ENC_FLUSH;
               end else if (dp_status.item_last) begin
                  state_in = ST_ENC_LAST;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (!dp_status.pair_phase) begin
               state_in = dp_status.item_last ? ST_DEC_FINAL : ST_IDLE;
            end else if (!dp_status.dec_error) begin
               state_in = ST_DEC_EXPAND;
            end else begin
               state_in = dp_status.item_last ? ST_DEC_FINAL : ST_IDLE;
            end
         end
         ST_ENC_FLUSH: begin
            if (dp_status.out_free) begin
               state_in = dp_status.item_last ? ST_ENC_LAST : ST_IDLE;
            end
         end
         ST_ENC_LAST: begin
            if (dp_status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DEC_EXPAND: begin
            if (dp_status.out_free && dp_status.expand_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_DEC_FINAL: begin
            if (dp_status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         ST_ENC_FLUSH: begin
            cmd.emit_flush = dp_status.out_free;
         end
         ST_ENC_LAST: begin
            cmd.emit_last_pair = dp_status.out_free;
         end
         ST_DEC_EXPAND: begin
            cmd.emit_expand = dp_status.out_free;
         end
         ST_DEC_FINAL: begin
            cmd.emit_final = dp_status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

`ifndef SYNTHESIS
   // a taken transaction is always evaluated in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> state_ff == ST_EVAL)
      else $error("taken transaction not evaluated");

   // at most one result is emitted per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_flush, cmd.emit_last_pair, cmd.emit_expand, cmd.emit_final}))
      else $error("more than one emit command");

   // input is only taken while no result generation is pending
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(cmd.eval || cmd.emit_flush || cmd.emit_expand || cmd.emit_final))
      else $error("input ready during item work");
`endif

endmodule

`default_nettype wire

FILE: sv/brlc_dp.sv
`default_nettype none

module brlc_dp (
   input  wire                       clock,
   input  wire                       reset,
   input  brlc_pkg::req_payload_type req_payload,
   input  wire                       csr_we,
   input  wire                       csr_index,
   input  wire  [31:0]               csr_wdata,
   input  brlc_pkg::cmd_type         cmd,
   output brlc_pkg::dp_status_type   dp_status,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output brlc_pkg::rsp_payload_type rsp_payload
);
   import brlc_pkg::*;

   // configuration
   logic        decode_mode_ff;
   logic [31:0] expected_size_ff;

   // held transaction
   logic [7:0]  item_byte_ff;
   logic        item_last_ff;

   // stream state
   logic [7:0]  run_value_ff, run_value_in;
   logic [7:0]  run_length_ff, run_length_in;
   logic        pair_phase_ff, pair_phase_in;
   logic [31:0] bytes_produced_ff, bytes_produced_in;
   logic [2:0]  error_code_ff, error_code_in;
   logic [7:0]  left_ff, left_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic        out_free;
   logic        enc_split;
   logic [32:0] room;
   logic [2:0]  check_code;
   logic [2:0]  error_next;
   logic [2:0]  final_status;
   logic [3:0]  lane_count;
   logic [63:0] lane_word;
   logic        expand_done;
   logic        any_emit;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign any_emit = cmd.emit_flush || cmd.emit_last_pair || cmd.emit_expand ||
                     cmd.emit_final;

   // encode: byte closes the open run
   assign enc_split = (run_length_ff != 8'd0) &&
                      !((item_byte_ff == run_value_ff) && (run_length_ff < MAX_RUN));

   // decode: pair checks, borrow in room means nothing counts as overflow
   assign room = {1'b0, expected_size_ff} - {1'b0, bytes_produced_ff};
   always_comb begin
      priority if (expected_size_ff > MAX_PAYLOAD_BYTES) begin
         check_code = STATUS_OVER_LIMIT;
      end else if (run_length_ff == 8'd0) begin
         check_code = STATUS_ZERO_COUNT;
      end else if (!room[32] && ({24'd0, run_length_ff} > room[31:0])) begin
         check_code = STATUS_OVERFLOW;
      end else begin
         check_code = STATUS_OK;
      end
   end
   assign error_next = (error_code_ff != STATUS_OK) ? error_code_ff : check_code;

   // status of the stream's final result
   always_comb begin
      priority if (pair_phase_ff) begin
         final_status = STATUS_ODD_LENGTH;
      end else if (error_code_ff != STATUS_OK) begin
         final_status = error_code_ff;
      end else if (bytes_produced_ff != expected_size_ff) begin
         final_status = STATUS_SIZE_MISMATCH;
      end else begin
         final_status = STATUS_OK;
      end
   end

   // run expansion lanes
   assign expand_done = (left_ff <= 8'(LANES));
   assign lane_count  = expand_done ? left_ff[3:0] : 4'(LANES);
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lane_word[8*i +: 8] = (4'(i) < lane_count) ? run_value_ff : 8'd0;
      end
   end

   // stream state and result next values
   always_comb begin
      run_value_in      = run_value_ff;
      run_length_in     = run_length_ff;
      pair_phase_in     = pair_phase_ff;
      bytes_produced_in = bytes_produced_ff;
      error_code_in     = error_code_ff;
      left_in           = left_ff;
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;

      if (cmd.eval) begin
         if (!decode_mode_ff) begin
            if (run_length_ff == 8'd0) begin
               run_value_in  = item_byte_ff;
               run_length_in = 8'd1;
            end else if (!enc_split) begin
               run_length_in = run_length_ff + 8'd1;
            end
         end else if (!pair_phase_ff) begin
            run_length_in = item_byte_ff;
            pair_phase_in = 1'b1;
         end else begin
            run_value_in  = item_byte_ff;
            pair_phase_in = 1'b0;
            error_code_in = error_next;
            if (error_next == STATUS_OK) begin
               left_in           = run_length_ff;
               bytes_produced_in = bytes_produced_ff + {24'd0, run_length_ff};
            end
         end
      end

      if (cmd.emit_flush) begin
         rsp_in.out_word  = {48'd0, run_value_ff, run_length_ff};
         rsp_in.out_count = 4'd2;
         rsp_in.out_last  = 1'b0;
         rsp_in.status    = STATUS_OK;
         run_value_in     = item_byte_ff;
         run_length_in    = 8'd1;
      end

      if (cmd.emit_last_pair) begin
         rsp_in.out_word  = {48'd0, run_value_ff, run_length_ff};
         rsp_in.out_count = 4'd2;
         rsp_in.out_last  = 1'b1;
         rsp_in.status    = STATUS_OK;
      end

      if (cmd.emit_expand) begin
         rsp_in.out_word  = lane_word;
         rsp_in.out_count = lane_count;
         rsp_in.out_last  = expand_done && item_last_ff;
         rsp_in.status    = (expand_done && item_last_ff) ? final_status : STATUS_OK;
         left_in          = left_ff - {4'd0, lane_count};
      end

      if (cmd.emit_final) begin
         rsp_in.out_word  = 64'd0;
         rsp_in.out_count = 4'd0;
         rsp_in.out_last  = 1'b1;
         rsp_in.status    = final_status;
      end

      if (any_emit) begin
         rsp_valid_in = 1'b1;
      end

      // stream ends with its final result
      if (cmd.emit_last_pair || cmd.emit_final || (cmd.emit_expand && expand_done &&
          item_last_ff)) begin
         run_value_in      = 8'd0;
         run_length_in     = 8'd0;
         pair_phase_in     = 1'b0;
         bytes_produced_in = 32'd0;
         error_code_in     = STATUS_OK;
      end
   end

   // control and stream registers
   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff    <= 1'b0;
         expected_size_ff  <= 32'd0;
         run_value_ff      <= 8'd0;
         run_length_ff     <= 8'd0;
         pair_phase_ff     <= 1'b0;
         bytes_produced_ff <= 32'd0;
         error_code_ff     <= STATUS_OK;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_we && (csr_index == CSR_DECODE_MODE)) begin
            decode_mode_ff <= csr_wdata[0];
         end
         if (csr_we && (csr_index == CSR_EXPECTED_SIZE)) begin
            expected_size_ff <= csr_wdata;
         end
         run_value_ff      <= run_value_in;
         run_length_ff     <= run_length_in;
         pair_phase_ff     <= pair_phase_in;
         bytes_produced_ff <= bytes_produced_in;
         error_code_ff     <= error_code_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         item_byte_ff <= req_payload.data_byte;
         item_last_ff <= req_payload.last_byte;
      end
      left_ff <= left_in;
      rsp_ff  <= rsp_in;
   end

   assign dp_status.decode_mode = decode_mode_ff;
   assign dp_status.item_last   = item_last_ff;
   assign dp_status.enc_split   = enc_split;
   assign dp_status.pair_phase  = pair_phase_ff;
   assign dp_status.dec_error   = (error_next != STATUS_OK);
   assign dp_status.expand_done = expand_done;
   assign dp_status.out_free    = out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // a result is never written over one still waiting
   assert property (@(posedge clock) disable iff (reset)
      any_emit |-> out_free)
      else $error("result overwritten");

   // lane count stays within the word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.out_count <= 4'(LANES))
      else $error("lane count beyond word");

   // error status only on the final result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.out_last) |-> rsp_ff.status == STATUS_OK)
      else $error("status on non-final result");

   // stream state is cleared after a final result
   assert property (@(posedge clock) disable iff (reset)
      (any_emit && rsp_in.out_last) |=>
         (run_length_ff == 8'd0 && !pair_phase_ff && bytes_produced_ff == 32'd0 &&
          error_code_ff == STATUS_OK))
      else $error("stream state kept after final result");
`endif

endmodule

`default_nettype wire

FILE: sv/byte_run_length_codec.sv
// an item is taken and evaluated in the next cycle, then its results follow one per cycle while
//   the result register is free or rsp_ready is high; a decoded run of n bytes gives ceil(n/8)
//   results of up to 8 bytes each
// the controller works on one item at a time through a single result register, so no new item
//   is taken before the results of the last one are written to that register
// reset (synchronous, active high) clears the configuration, the stream state and rsp_valid
`default_nettype none

module byte_run_length_codec (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  brlc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output brlc_pkg::rsp_payload_type rsp_payload,
   input  wire                       csr_we,
   input  wire                       csr_index,
   input  wire  [31:0]               csr_wdata
);
   import brlc_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_status;

   // sequencing
   brlc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // run state, checks and result register
   brlc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: bench/tb_byte_run_length_codec.sv
`timescale 1ns / 1ps

module tb_byte_run_length_codec;
   import brlc_pkg::*;

   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 170;

   localparam rsp_payload_type NO_RESULT = '0;

   // one directed transaction, with an optional register update before it
   typedef struct {
      logic            set_cfg;
      logic            mode;
      logic [31:0]     size;
      logic [7:0]      data;
      logic            last;
      logic            typed;
      rsp_payload_type want;
   } byte_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_we = 1'b0;
   logic            csr_index = 1'b0;
   logic [31:0]     csr_wdata = '0;

   // hand-written expectation that travels with a directed transaction
   logic            item_typed = 1'b0;
   rsp_payload_type item_want = '0;

   // register copies and stream state of the predictor
   logic            mode_decode = 1'b0;
   logic [31:0]     size_expected = '0;
   logic [7:0]      run_byte = '0;
   logic [7:0]      run_count = '0;
   logic            pair_half = 1'b0;
   logic [31:0]     decoded_total = '0;
   logic [2:0]      stream_error = STATUS_OK;

   rsp_payload_type pending_results[$];

   int mismatches = 0;
   int results_checked = 0;
   int items_sent = 0;
   int streams_started = 0;
   int cycle_count = 0;
   int send_gap_pct = 13;
   int recv_gap_pct = 61;
   int final_status_hits[8];

   byte_row_type directed_bytes[30] = '{
      // single-byte encode streams at both byte extremes
      '{1'b1, 1'b0, 32'd0, 8'h00, 1'b1, 1'b1, '{64'h0001, 4'd2, 1'b1, STATUS_OK}},
      '{1'b0, 1'b0, 32'd0, 8'hFF, 1'b1, 1'b1, '{64'hFF01, 4'd2, 1'b1, STATUS_OK}},
      // run of two then a different byte
      '{1'b0, 1'b0, 32'd0, 8'hAA, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b0, 32'd0, 8'hAA, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b0, 32'd0, 8'h55, 1'b1, 1'b0, NO_RESULT},
      // decode: zero count
      '{1'b1, 1'b1, 32'd3, 8'h00, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 32'd3, 8'h11, 1'b1, 1'b1, '{64'd0, 4'd0, 1'b1, STATUS_ZERO_COUNT}},
      // count beyond the declared size
      '{1'b1, 1'b1, 32'd3, 8'h05, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 32'd3, 8'h22, 1'b1, 1'b1, '{64'd0, 4'd0, 1'b1, STATUS_OVERFLOW}},
      // stream ends on a count byte
      '{1'b1, 1'b1, 32'd1, 8'h01, 1'b1, 1'b1, '{64'd0, 4'd0, 1'b1, STATUS_ODD_LENGTH}},
      // declared size just above the limit
      '{1'b1, 1'b1, MAX_PAYLOAD_BYTES + 32'd1, 8'h01, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 32'd0, 8'h33, 1'b1, 1'b1, '{64'd0, 4'd0, 1'b1, STATUS_OVER_LIMIT}},
      // size at the limit, longest run expands into the most results
      '{1'b1, 1'b1, MAX_PAYLOAD_BYTES, 8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 32'd0, 8'hEE, 1'b1, 1'b0, NO_RESULT},
      // two runs that fall one byte short
      '{1'b1, 1'b1, 32'd4, 8'h02, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 32'd0, 8'h44, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 32'd0, 8'h01, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 32'd0, 8'h45, 1'b1, 1'b0, NO_RESULT},
      // zero count recorded, then odd length takes over
      '{1'b1, 1'b1, 32'd2, 8'h00, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 32'd0, 8'h01, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 32'd0, 8'h07, 1'b1, 1'b1, '{64'd0, 4'd0, 1'b1, STATUS_ODD_LENGTH}},
      // open encode run, then decode picks up the same stream
      '{1'b1, 1'b0, 32'd9, 8'h09, 1'b0, 1'b0, NO_RESULT},
      '{1'b1, 1'b1, 32'd9, 8'h09, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b1, 32'd0, 8'h61, 1'b1, 1'b0, NO_RESULT},
      // pending decode count, then encode resumes on it
      '{1'b1, 1'b1, 32'd0, 8'h03, 1'b0, 1'b0, NO_RESULT},
      '{1'b1, 1'b0, 32'd0, 8'h5A, 1'b1, 1'b0, NO_RESULT},
      // pending count of 254, then encode grows the run to its cap and past it
      '{1'b1, 1'b1, 32'd0, 8'hFE, 1'b0, 1'b0, NO_RESULT},
      '{1'b1, 1'b0, 32'd0, 8'h00, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b0, 32'd0, 8'h00, 1'b0, 1'b0, NO_RESULT},
      '{1'b0, 1'b0, 32'd0, 8'h00, 1'b1, 1'b0, NO_RESULT}
   };

   byte_run_length_codec uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [2:0] closing_status(input logic odd);
      if (odd)
         return STATUS_ODD_LENGTH;
      if (stream_error != STATUS_OK)
         return stream_error;
      if (decoded_total != size_expected)
         return STATUS_SIZE_MISMATCH;
      return STATUS_OK;
   endfunction

   function automatic rsp_payload_type pair_result(input logic last);
      rsp_payload_type r;
      r.out_word = {48'd0, run_byte, run_count};
      r.out_count = 4'd2;
      r.out_last = last;
      r.status = STATUS_OK;
      return r;
   endfunction

   function automatic rsp_payload_type empty_final(input logic [2:0] code);
      rsp_payload_type r;
      r = '0;
      r.out_last = 1'b1;
      r.status = code;
      return r;
   endfunction

   task automatic clear_stream_state;
      run_byte = '0;
      run_count = '0;
      pair_half = 1'b0;
      decoded_total = '0;
      stream_error = STATUS_OK;
   endtask

   // append one expected result
   task automatic queue_result(input rsp_payload_type r);
      pending_results = {pending_results, r};
   endtask

   // expected results of one accepted byte
   task automatic predict_codec(input logic [7:0] b, input logic last);
      rsp_payload_type r;
      logic [7:0] left;
      logic [3:0] lanes;
      int lane;
      if (!mode_decode) begin
         // encode: extend the run or close it
         if (run_count == 8'd0) begin
            run_byte = b;
            run_count = 8'd1;
         end else if (b == run_byte && run_count < MAX_RUN) begin
            run_count = run_count + 8'd1;
         end else begin
            queue_result(pair_result(1'b0));
            run_byte = b;
            run_count = 8'd1;
         end
         if (last) begin
            queue_result(pair_result(1'b1));
            clear_stream_state();
         end
      end else if (!pair_half) begin
         // decode: count byte
         run_count = b;
         pair_half = 1'b1;
         if (last) begin
            queue_result(empty_final(closing_status(1'b1)));
            clear_stream_state();
         end
      end else begin
         // decode: value byte completes the pair
         run_byte = b;
         pair_half = 1'b0;
         if (stream_error == STATUS_OK) begin
            if (size_expected > MAX_PAYLOAD_BYTES)
               stream_error = STATUS_OVER_LIMIT;
            else if (run_count == 8'd0)
               stream_error = STATUS_ZERO_COUNT;
            else if ({56'd0, run_count} > {32'd0, size_expected} - {32'd0, decoded_total})
               stream_error = STATUS_OVERFLOW;
         end
         if (stream_error == STATUS_OK) begin
            decoded_total = decoded_total + {24'd0, run_count};
            left = run_count;
            while (left != 8'd0) begin
               lanes = (left > 8'd8) ? 4'd8 : left[3:0];
               r.out_word = '0;
               for (lane = 0; lane < int'(lanes); lane++)
                  r.out_word[8*lane +: 8] = run_byte;
               left = left - {4'd0, lanes};
               r.out_count = lanes;
               r.out_last = last && (left == 8'd0);
               r.status = r.out_last ? closing_status(1'b0) : STATUS_OK;
               queue_result(r);
            end
         end else if (last) begin
            queue_result(empty_final(closing_status(1'b0)));
         end
         if (last)
            clear_stream_state();
      end
   endtask

   task automatic check_field(input string field, input logic [63:0] want_v,
                              input logic [63:0] got_v);
      if (want_v !== got_v) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
      end
   endtask

   // predict on each input transaction, check each result transaction
   always @(posedge clock) begin
      int mark;
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            mark = pending_results.size();
            predict_codec(req_payload.data_byte, req_payload.last_byte);
            if (item_typed) begin
               while (pending_results.size() > mark)
                  void'(pending_results.pop_back());
               queue_result(item_want);
            end
         end
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual %h", $time,
                        rsp_payload);
            end else begin
               want = pending_results.pop_front();
               check_field("out_word", want.out_word, rsp_payload.out_word);
               check_field("out_count", 64'(want.out_count), 64'(rsp_payload.out_count));
               check_field("out_last", 64'(want.out_last), 64'(rsp_payload.out_last));
               check_field("status", 64'(want.status), 64'(rsp_payload.status));
               if (rsp_payload.out_last)
                  final_status_hits[rsp_payload.status]++;
            end
         end
      end
   end

   // one input transaction, with a random gap before it
   task automatic send_item(input logic [7:0] b, input logic last, input logic typed,
                            input rsp_payload_type want);
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_payload <= '{data_byte: b, last_byte: last};
      item_typed <= typed;
      item_want <= want;
      do
         @(posedge clock);
      while (!(req_valid && req_ready));
      items_sent++;
   endtask

   // hold off until every result is in and the block has settled
   task automatic wait_idle;
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic mode, input logic [31:0] size);
      csr_we <= 1'b1;
      csr_index <= CSR_DECODE_MODE;
      csr_wdata <= {31'd0, mode};
      @(posedge clock);
      mode_decode = mode;
      csr_index <= CSR_EXPECTED_SIZE;
      csr_wdata <= size;
      @(posedge clock);
      size_expected = size;
      csr_we <= 1'b0;
   endtask

   // raw bytes grouped into short runs, mostly from a small alphabet
   task automatic run_encode_stream;
      int n_runs;
      int run_len;
      int r;
      int j;
      logic [7:0] v;
      logic close;
      n_runs = $urandom_range(1, 5);
      close = ($urandom_range(9) != 0);
      configure(1'b0, $urandom());
      streams_started++;
      for (r = 0; r < n_runs; r++) begin
         v = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
         run_len = $urandom_range(1, 6);
         for (j = 0; j < run_len; j++)
            send_item(v, close && r == n_runs - 1 && j == run_len - 1, 1'b0, NO_RESULT);
      end
   endtask

   // pair stream, mostly sized to match, sometimes broken
   task automatic run_decode_stream;
      logic [7:0] counts[4];
      logic [7:0] values[4];
      int n_pairs;
      int p;
      int pick;
      logic [31:0] total;
      logic [31:0] size;
      logic close;
      logic odd;
      n_pairs = $urandom_range(1, 4);
      total = '0;
      for (p = 0; p < n_pairs; p++) begin
         pick = $urandom_range(19);
         if (pick == 0)
            counts[p] = 8'd0;
         else if (pick < 4)
            counts[p] = 8'($urandom_range(255));
         else
            counts[p] = 8'($urandom_range(1, 24));
         values[p] = 8'($urandom_range(255));
         total = total + {24'd0, counts[p]};
      end
      pick = $urandom_range(19);
      if (pick < 13)
         size = total;
      else if (pick < 15)
         size = total + 32'($urandom_range(1, 3));
      else if (pick == 15)
         size = total - 32'd1;
      else if (pick == 16)
         size = 32'd0;
      else if (pick == 17)
         size = MAX_PAYLOAD_BYTES;
      else if (pick == 18)
         size = MAX_PAYLOAD_BYTES + 32'd1;
      else
         size = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF : $urandom();
      close = ($urandom_range(9) != 0);
      odd = ($urandom_range(9) == 0);
      configure(1'b1, size);
      streams_started++;
      for (p = 0; p < n_pairs; p++) begin
         if (odd && p == n_pairs - 1) begin
            send_item(counts[p], close, 1'b0, NO_RESULT);
         end else begin
            send_item(counts[p], 1'b0, 1'b0, NO_RESULT);
            send_item(values[p], close && p == n_pairs - 1, 1'b0, NO_RESULT);
         end
      end
   endtask

   initial begin
      int start;
      int progress;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_bytes[i]) begin
         if (directed_bytes[i].set_cfg) begin
            wait_idle();
            configure(directed_bytes[i].mode, directed_bytes[i].size);
         end
         send_item(directed_bytes[i].data, directed_bytes[i].last,
                   directed_bytes[i].typed, directed_bytes[i].want);
      end

      // random streams under three idling patterns
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         progress = items_sent - start;
         if (progress < RANDOM_ITEMS / 3) begin
            send_gap_pct = 13;
            recv_gap_pct = 61;
         end else if (progress < 2 * RANDOM_ITEMS / 3) begin
            send_gap_pct = 61;
            recv_gap_pct = 13;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         wait_idle();
         if ($urandom_range(1) == 0)
            run_encode_stream();
         else
            run_decode_stream();
      end

      wait_idle();
      $display("%0d bytes sent over the table and %0d random streams, %0d results checked",
               items_sent, streams_started, results_checked);
      $display("final status: ok %0d odd %0d zero %0d overflow %0d mismatch %0d limit %0d",
               final_status_hits[STATUS_OK], final_status_hits[STATUS_ODD_LENGTH],
               final_status_hits[STATUS_ZERO_COUNT], final_status_hits[STATUS_OVERFLOW],
               final_status_hits[STATUS_SIZE_MISMATCH], final_status_hits[STATUS_OVER_LIMIT]);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: files.f
sv/brlc_pkg.sv
sv/brlc_ctrl.sv
sv/brlc_dp.sv
sv/byte_run_length_codec.sv
bench/tb_byte_run_length_codec.sv
